/* src/urav_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range average package
// Shared types, field widths and fixed-point constants for the echo
// conversion and the averaging pipeline.
// ----------------------------------------------------------------------------
package urav_pkg;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned ECHO_W = 15;
    localparam int unsigned MM_W   = 13;

    localparam int unsigned MAX_MM = 5649;
    localparam logic [MM_W-1:0] MAX_DIST_RESET = 13'd300;

    localparam logic [KIND_W-1:0] KIND_ECHO     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NO_PULSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;

    // Echo width to millimeters: floor(w * ECHO_SCALE / ECHO_DIV), done as one
    // multiply by a scaled reciprocal that is exact for w * ECHO_SCALE < 2^19.
    localparam longint unsigned ECHO_SCALE  = 10;
    localparam longint unsigned ECHO_DIV    = 58;
    localparam int unsigned     CONV_SHIFT  = 25;
    localparam int unsigned     CONV_MULT_W = 23;
    localparam logic [CONV_MULT_W-1:0] CONV_MULT = CONV_MULT_W'(
        ECHO_SCALE * (((64'd1 << CONV_SHIFT) + ECHO_DIV - 64'd1) / ECHO_DIV));

    typedef enum logic [1:0] {
        SRC_ECHO,
        SRC_LAST,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        src_t             src;
        logic [MM_W-1:0]  echo_mm;
    } conv_t;

endpackage

/* src/urav_echo_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo conversion
// Classifies one ranging attempt and converts the echo width in microseconds
// to a distance in millimeters.
// ----------------------------------------------------------------------------
module urav_echo_conv
    import urav_pkg::*;
(
    input  logic [KIND_W-1:0] kind,
    input  logic [ECHO_W-1:0] echo_us,
    output conv_t             conv
);

    localparam int unsigned PROD_W = ECHO_W + CONV_MULT_W;

    logic [PROD_W-1:0] product;

    assign product = PROD_W'(echo_us) * PROD_W'(CONV_MULT);

    always_comb begin
        conv.echo_mm = MM_W'(product >> CONV_SHIFT);
        unique case (kind)
            KIND_ECHO:     conv.src = (echo_us != '0) ? SRC_ECHO : SRC_LAST;
            KIND_NO_PULSE: conv.src = SRC_LAST;
            KIND_TIMEOUT:  conv.src = SRC_ZERO;
            default:       conv.src = SRC_ZERO;
        endcase
    end

endmodule

/* src/ultrasonic_range_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range average unit
// Converts ultrasonic echo widths to distances and keeps a moving average
// over a ring of the most recent readings.
// ----------------------------------------------------------------------------
// Beats pass a conversion stage register and then an output register.
// Throughput is one beat per cycle while m_tready does not stall the output;
// the sum and average are combinational; every accepted beat updates the state.
// Reset clears the ring through per-entry valid bits, the running sum, the
// write index and the last distance, and sets the maximum distance to 300.
// ----------------------------------------------------------------------------
module ultrasonic_range_average_unit
    import urav_pkg::*;
#(
    parameter int unsigned SAMPLE_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wen,
    input  logic [12:0] cfg_wdata,    // max_distance_mm

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [14:0] echo_us, [15] zero
    input  logic [1:0]  s_tuser,      // [1:0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // [12:0] reading_mm, [25:13] average_mm,
                                      // [26] target_seen, [31:27] zero
);

    localparam int unsigned IDX_W    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int unsigned SUM_W    = $clog2(SAMPLE_COUNT * MAX_MM + 1);
    localparam int unsigned AVG_L    = $clog2(SAMPLE_COUNT);
    localparam int unsigned AVG_K    = SUM_W + AVG_L;
    localparam int unsigned RECIP_W  = SUM_W + 1;
    localparam int unsigned PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(
        ((64'd1 << AVG_K) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);

    conv_t                   conv;
    conv_t                   conv_reg;
    logic                    stage_valid_reg;
    logic                    out_free;
    logic                    s_fire;
    logic                    fire;

    logic [MM_W-1:0]         max_dist_reg;
    logic [MM_W-1:0]         last_dist_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [IDX_W-1:0]        rd_addr;
    logic [SAMPLE_COUNT-1:0] entry_valid_reg;

    logic [MM_W-1:0]         ring [SAMPLE_COUNT];
    logic [MM_W-1:0]         ring_rd_reg;
    logic                    rd_valid_reg;
    logic                    bypass_reg;
    logic [MM_W-1:0]         bypass_data_reg;
    logic [MM_W-1:0]         oldest;

    logic [MM_W-1:0]         reading;
    logic [PROD_W-1:0]       avg_prod;
    logic [MM_W-1:0]         average;
    logic                    target;

    logic                    m_tvalid_reg;
    logic [MM_W-1:0]         reading_reg;
    logic [MM_W-1:0]         average_reg;
    logic                    target_reg;

    urav_echo_conv u_echo_conv (
        .kind    (s_tuser),
        .echo_us (s_tdata[ECHO_W-1:0]),
        .conv    (conv)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = stage_valid_reg && out_free;
    assign s_tready = !stage_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        unique case (conv_reg.src)
            SRC_ECHO: reading = conv_reg.echo_mm;
            SRC_LAST: reading = last_dist_reg;
            SRC_ZERO: reading = '0;
            default:  reading = '0;
        endcase

        if (bypass_reg) begin
            oldest = bypass_data_reg;
        end else if (rd_valid_reg) begin
            oldest = ring_rd_reg;
        end else begin
            oldest = '0;
        end

        sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(reading);
        avg_prod = PROD_W'(sum_next) * PROD_W'(AVG_RECIP);
        average  = MM_W'(avg_prod >> AVG_K);
        target   = (average != '0) && (average <= max_dist_reg);

        idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
        rd_addr  = fire ? idx_next : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            ring[idx_reg] <= reading;
        end
        ring_rd_reg     <= ring[rd_addr];
        bypass_data_reg <= reading;
        if (s_fire) begin
            conv_reg <= conv;
        end
        if (fire) begin
            reading_reg <= reading;
            average_reg <= average;
            target_reg  <= target;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            max_dist_reg    <= MAX_DIST_RESET;
            last_dist_reg   <= '0;
            sum_reg         <= '0;
            idx_reg         <= '0;
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            bypass_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                max_dist_reg <= cfg_wdata;
            end
            if (s_fire) begin
                stage_valid_reg <= 1'b1;
            end else if (fire) begin
                stage_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (fire) begin
                last_dist_reg            <= average;
                sum_reg                  <= sum_next;
                idx_reg                  <= idx_next;
                entry_valid_reg[idx_reg] <= 1'b1;
            end
            rd_valid_reg <= entry_valid_reg[rd_addr];
            bypass_reg   <= fire && (rd_addr == idx_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, target_reg, average_reg, reading_reg};

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_LAST)
        else $error("ring write index out of range");

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_W'(SAMPLE_COUNT * MAX_MM))
        else $error("running sum exceeds the largest ring total");

    a_avg_follows_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (last_dist_reg == average_reg) && m_tvalid_reg)
        else $error("last distance does not track the delivered average");

    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && target_reg |-> (average_reg != '0) && (average_reg <= MM_W'(MAX_MM)))
        else $error("target flag set for an average outside the valid range");
`endif

endmodule
